@@ sv/assert_macros.svh @@
// Assertion macros shared by the booking queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold at the edge where ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold at the edge after the one where ante holds
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bpq_pkg.sv @@
// Types, constants and calendar helpers for the booking priority queue.
package bpq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int WORKER_COUNT_DEF = 5;
    localparam logic [3:0] BUMP_RESET = 4'd5;
    localparam int MONTHS = 12;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_TAKE    = 2'd1,
        CMD_RESCHED = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_MOVED   = 3'd1,
        STAT_NO_DATE = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_NONE    = 3'd4,
        STAT_BAD_POS = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BUMP,
        ST_SCAN,
        ST_DONE
    } t_state;

    // field order makes a plain vector compare the calendar order
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    typedef struct packed {
        logic [2:0] worker;
        logic [2:0] urgency;
        t_date      date;
    } t_entry;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  worker;
        logic [2:0]  urgency;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [3:0]  position;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  out_position;
        logic [2:0]  out_worker;
        logic [2:0]  out_urgency;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic shift;
        logic live;
        logic skip;
    } t_cell_en;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic t_date next_day(input t_date d);
        logic [4:0] len;
        logic [5:0] dn;
        logic [4:0] mn;
        t_date      r;
        len = month_len(d.month);
        dn  = {1'b0, d.day} + 6'd1;
        mn  = {1'b0, d.month} + 5'd1;
        r   = d;
        if (dn > {1'b0, len}) begin
            r.day = 5'd1;
            if (mn > 5'(MONTHS)) begin
                r.month = 4'd1;
                r.year  = d.year + 14'd1;
            end else begin
                r.month = mn[3:0];
            end
        end else begin
            r.day = dn[4:0];
        end
        return r;
    endfunction

    function automatic t_out_item make_result(input t_status st, input logic [3:0] pos,
                                              input t_entry e);
        t_out_item r;
        r.status       = st;
        r.out_position = pos;
        r.out_worker   = e.worker;
        r.out_urgency  = e.urgency;
        r.out_day      = e.date.day;
        r.out_month    = e.date.month;
        r.out_year     = e.date.year;
        return r;
    endfunction

    function automatic t_out_item fail_result(input t_status st);
        t_out_item r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

endpackage

@@ sv/booking_priority_queue_unit.sv @@
// Booking priority queue: top level with control sequencer and the row of slot cells.
//
// Queue of up to QUEUE_DEPTH bookings held in a row of slot cells. One command is worked
// at a time; a new command transfer is taken as soon as the previous result sits in the
// output register. Insert and reschedule try one date at a time: all cells compare the
// candidate date in parallel (CHECK), then the sequencer decides or moves a day (BUMP),
// up to max_bumps moves. Take reads the live entries one per cycle through the cell read
// port and then shifts the tail down. Bad commands (full, bad worker, bad position) go
// straight to the result. max_bumps resets to 5 and is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while idle, the block does not enforce it.
`include "assert_macros.svh"

module booking_priority_queue_unit #(
    parameter int QUEUE_DEPTH  = bpq_pkg::QUEUE_DEPTH_DEF,
    parameter int WORKER_COUNT = bpq_pkg::WORKER_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpq_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PW    = (CNT_W > 4) ? CNT_W : 4;

    bpq_pkg::t_state    r_state;
    bpq_pkg::t_state    n_state;
    logic [CNT_W-1:0]   r_count;
    logic [3:0]         r_max_bumps;
    logic               r_out_valid;
    bpq_pkg::t_out_item r_out;

    bpq_pkg::t_cmd      r_cmd;
    bpq_pkg::t_entry    r_item;
    logic [IDX_W-1:0]   r_pos;
    logic [3:0]         r_tries;
    logic               r_moved;
    logic [QUEUE_DEPTH-1:0] r_hits;
    logic [CNT_W-1:0]   r_scan;
    logic               r_found;
    bpq_pkg::t_entry    r_best;
    logic [IDX_W-1:0]   r_best_idx;
    bpq_pkg::t_out_item r_res;

    bpq_pkg::t_entry    w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_hits;
    bpq_pkg::t_entry    w_rd;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_in_fire;
    logic               w_out_load;
    logic               w_any_hit;
    logic               w_scan_end;
    logic               w_better;
    logic               w_full;
    logic               w_bad_worker;
    logic               w_bad_pos;
    logic               w_wr_en;
    logic               w_shift_en;
    logic               w_skip_en;
    bpq_pkg::t_entry    w_in_entry;

    // slot row
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        bpq_pkg::t_cell_en w_en;
        bpq_pkg::t_entry   w_next;

        assign w_en.load  = w_wr_en && (IDX_W'(gi) == r_pos);
        assign w_en.shift = w_shift_en && (IDX_W'(gi) >= r_best_idx);
        assign w_en.live  = CNT_W'(gi) < r_count;
        assign w_en.skip  = w_skip_en && (IDX_W'(gi) == r_pos);

        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_entry[gi];
        end else begin : g_mid
            assign w_next = w_entry[gi + 1];
        end

        bpq_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_item  (r_item),
            .i_next  (w_next),
            .o_entry (w_entry[gi]),
            .o_hit   (w_hits[gi])
        );
    end

    assign w_rd = w_entry[w_rd_addr];

    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_out_load   = (r_state == bpq_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
    assign w_any_hit    = |r_hits;
    assign w_scan_end   = (r_scan == r_count);
    assign w_full       = r_count >= CNT_W'(QUEUE_DEPTH);
    assign w_bad_worker = {1'b0, i_in_data.worker} >= 4'(WORKER_COUNT);
    assign w_bad_pos    = PW'(i_in_data.position) >= PW'(r_count);
    assign w_better     = (w_rd.worker == r_item.worker) &&
                          (!r_found || (w_rd.urgency > r_best.urgency) ||
                           ((w_rd.urgency == r_best.urgency) &&
                            (w_rd.date < r_best.date)));

    assign w_in_entry.worker     = i_in_data.worker;
    assign w_in_entry.urgency    = i_in_data.urgency;
    assign w_in_entry.date.year  = i_in_data.year;
    assign w_in_entry.date.month = i_in_data.month;
    assign w_in_entry.date.day   = i_in_data.day;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpq_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    case (bpq_pkg::t_cmd'(i_in_data.cmd))
                        bpq_pkg::CMD_INSERT:  n_state = w_full ? bpq_pkg::ST_DONE
                                                               : bpq_pkg::ST_CHECK;
                        bpq_pkg::CMD_TAKE:    n_state = w_bad_worker ? bpq_pkg::ST_DONE
                                                                     : bpq_pkg::ST_SCAN;
                        bpq_pkg::CMD_RESCHED: n_state = w_bad_pos ? bpq_pkg::ST_DONE
                                                                  : bpq_pkg::ST_CHECK;
                        default:              n_state = bpq_pkg::ST_IDLE;
                    endcase
                end
            end
            bpq_pkg::ST_CHECK: n_state = bpq_pkg::ST_BUMP;
            bpq_pkg::ST_BUMP: begin
                if (w_any_hit && (r_tries < r_max_bumps)) begin
                    n_state = bpq_pkg::ST_CHECK;
                end else begin
                    n_state = bpq_pkg::ST_DONE;
                end
            end
            bpq_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = bpq_pkg::ST_DONE;
                end
            end
            bpq_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = bpq_pkg::ST_IDLE;
                end
            end
            default: n_state = bpq_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_wr_en    = 1'b0;
        w_shift_en = 1'b0;
        w_rd_addr  = r_pos;
        unique case (r_state)
            bpq_pkg::ST_IDLE: o_in_ready = 1'b1;
            bpq_pkg::ST_BUMP: w_wr_en = !w_any_hit;
            bpq_pkg::ST_SCAN: begin
                w_rd_addr  = r_scan[IDX_W-1:0];
                w_shift_en = w_scan_end && r_found;
            end
            default: ;
        endcase
    end

    assign w_skip_en = (r_cmd == bpq_pkg::CMD_RESCHED);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpq_pkg::ST_IDLE;
            r_count     <= '0;
            r_max_bumps <= bpq_pkg::BUMP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_bumps <= i_cfg_wdata;
            end
            if (w_wr_en && (r_cmd == bpq_pkg::CMD_INSERT)) begin
                r_count <= r_count + 1'b1;
            end else if (w_shift_en) begin
                r_count <= r_count - 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bpq_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    r_cmd   <= bpq_pkg::t_cmd'(i_in_data.cmd);
                    r_item  <= w_in_entry;
                    r_tries <= '0;
                    r_moved <= 1'b0;
                    r_scan  <= '0;
                    r_found <= 1'b0;
                    if (bpq_pkg::t_cmd'(i_in_data.cmd) == bpq_pkg::CMD_INSERT) begin
                        r_pos <= r_count[IDX_W-1:0];
                    end else begin
                        r_pos <= IDX_W'(i_in_data.position);
                    end
                    priority if (bpq_pkg::t_cmd'(i_in_data.cmd) == bpq_pkg::CMD_INSERT) begin
                        r_res <= bpq_pkg::fail_result(bpq_pkg::STAT_FULL);
                    end else if (bpq_pkg::t_cmd'(i_in_data.cmd) == bpq_pkg::CMD_TAKE) begin
                        r_res <= bpq_pkg::fail_result(bpq_pkg::STAT_NONE);
                    end else begin
                        r_res <= bpq_pkg::fail_result(bpq_pkg::STAT_BAD_POS);
                    end
                end
            end
            bpq_pkg::ST_CHECK: begin
                r_hits <= w_hits;
                if (r_cmd == bpq_pkg::CMD_RESCHED) begin
                    r_item.worker  <= w_rd.worker;
                    r_item.urgency <= w_rd.urgency;
                end
            end
            bpq_pkg::ST_BUMP: begin
                if (w_any_hit) begin
                    r_moved <= 1'b1;
                    if (r_tries >= r_max_bumps) begin
                        r_res <= bpq_pkg::fail_result(bpq_pkg::STAT_NO_DATE);
                    end else begin
                        r_item.date <= bpq_pkg::next_day(r_item.date);
                        r_tries     <= r_tries + 1'b1;
                    end
                end else begin
                    r_res <= bpq_pkg::make_result(
                        r_moved ? bpq_pkg::STAT_MOVED : bpq_pkg::STAT_OK, 4'(r_pos), r_item);
                end
            end
            bpq_pkg::ST_SCAN: begin
                if (!w_scan_end) begin
                    if (w_better) begin
                        r_best     <= w_rd;
                        r_best_idx <= r_scan[IDX_W-1:0];
                        r_found    <= 1'b1;
                    end
                    r_scan <= r_scan + 1'b1;
                end else if (r_found) begin
                    r_res <= bpq_pkg::make_result(bpq_pkg::STAT_OK, 4'(r_best_idx), r_best);
                end else begin
                    r_res <= bpq_pkg::fail_result(bpq_pkg::STAT_NONE);
                end
            end
            bpq_pkg::ST_DONE: begin
                if (w_out_load) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH), "count over depth")
    `ASSERT_IMPLIES_NEXT(a_insert_grows, i_clk, i_rst_n, w_wr_en && (r_cmd == bpq_pkg::CMD_INSERT), r_count == $past(r_count) + 1'b1, "insert did not grow queue")
    `ASSERT_IMPLIES_NEXT(a_take_shrinks, i_clk, i_rst_n, w_shift_en, r_count == $past(r_count) - 1'b1, "take did not shrink queue")
    `ASSERT_IMPLIES(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status == bpq_pkg::STAT_NO_DATE || o_out_data.status == bpq_pkg::STAT_FULL || o_out_data.status == bpq_pkg::STAT_NONE || o_out_data.status == bpq_pkg::STAT_BAD_POS), o_out_data.out_urgency == 3'd0, "failed result carries entry")

endmodule

@@ sv/bpq_cell.sv @@
// One queue slot: holds an entry, loads, shifts from its neighbor, flags a date clash.
module bpq_cell (
    input  logic              i_clk,
    input  bpq_pkg::t_cell_en i_en,
    input  bpq_pkg::t_entry   i_item,
    input  bpq_pkg::t_entry   i_next,
    output bpq_pkg::t_entry   o_entry,
    output logic              o_hit
);

    bpq_pkg::t_entry r_entry;
    bpq_pkg::t_entry n_entry;

    always_comb begin
        priority if (i_en.load) begin
            n_entry = i_item;
        end else if (i_en.shift) begin
            n_entry = i_next;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_hit   = i_en.live && !i_en.skip && (r_entry.date == i_item.date);

endmodule

@@ test/booking_checker.sv @@
// Result checker for the booking priority queue: tracks the queue and compares every result.
`timescale 1ns / 100ps

module booking_checker #(
    parameter int QUEUE_DEPTH  = bpq_pkg::QUEUE_DEPTH_DEF,
    parameter int WORKER_COUNT = bpq_pkg::WORKER_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bpq_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bpq_pkg::t_out_item i_out_data,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    import bpq_pkg::*;

    t_entry     slots [QUEUE_DEPTH];
    int         live_count;
    logic [3:0] bump_limit;
    t_out_item  awaited [$];

    function automatic int month_days(input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int date_rank(input t_date d);
        return d.year * 10000 + d.month * 100 + d.day;
    endfunction

    function automatic t_date day_after(input t_date d);
        t_date r;
        int    dd;
        int    mm;
        r  = d;
        dd = int'(d.day) + 1;
        mm = int'(d.month) + 1;
        if (dd > month_days(int'(d.month))) begin
            r.day = 5'd1;
            if (mm > 12) begin
                r.month = 4'd1;
                r.year  = d.year + 14'd1;
            end else begin
                r.month = 4'(mm);
            end
        end else begin
            r.day = 5'(dd);
        end
        return r;
    endfunction

    function automatic logic date_clash(input t_date d, input int skip);
        for (int i = 0; i < live_count; i++) begin
            if (i != skip && date_rank(slots[i].date) == date_rank(d)) return 1'b1;
        end
        return 1'b0;
    endfunction

    // push the date forward past occupied days, within the bump budget
    function automatic t_status settle_date(inout t_date d, input int skip);
        int   tries;
        logic moved;
        tries = 0;
        moved = 1'b0;
        while (date_clash(d, skip)) begin
            moved = 1'b1;
            if (tries >= int'(bump_limit)) return STAT_NO_DATE;
            d = day_after(d);
            tries++;
        end
        if (moved) return STAT_MOVED;
        return STAT_OK;
    endfunction

    function automatic t_out_item refused(input t_status st);
        t_out_item r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    function automatic t_out_item granted(input t_status st, input int pos, input t_entry e);
        t_out_item r;
        r.status       = st;
        r.out_position = 4'(pos);
        r.out_worker   = e.worker;
        r.out_urgency  = e.urgency;
        r.out_day      = e.date.day;
        r.out_month    = e.date.month;
        r.out_year     = e.date.year;
        return r;
    endfunction

    task automatic apply_command(input t_in_item it, output logic has, output t_out_item r);
        t_entry  e;
        t_date   dt;
        t_status st;
        int      best;
        logic    found;
        e.worker     = it.worker;
        e.urgency    = it.urgency;
        dt.day       = it.day;
        dt.month     = it.month;
        dt.year      = it.year;
        e.date       = dt;
        r            = '0;
        has          = 1'b1;
        case (it.cmd)
            CMD_INSERT: begin
                if (live_count >= QUEUE_DEPTH) begin
                    r = refused(STAT_FULL);
                end else begin
                    st = settle_date(dt, -1);
                    if (st == STAT_NO_DATE) begin
                        r = refused(st);
                    end else begin
                        e.date            = dt;
                        slots[live_count] = e;
                        r                 = granted(st, live_count, e);
                        live_count++;
                    end
                end
            end
            CMD_TAKE: begin
                found = 1'b0;
                best  = 0;
                if (int'(it.worker) < WORKER_COUNT) begin
                    for (int i = 0; i < live_count; i++) begin
                        if (slots[i].worker == it.worker) begin
                            if (!found) begin
                                found = 1'b1;
                                best  = i;
                            end else if (slots[i].urgency > slots[best].urgency) begin
                                best = i;
                            end else if (slots[i].urgency == slots[best].urgency &&
                                         date_rank(slots[i].date) <
                                         date_rank(slots[best].date)) begin
                                best = i;
                            end
                        end
                    end
                end
                if (!found) begin
                    r = refused(STAT_NONE);
                end else begin
                    e = slots[best];
                    for (int i = best; i < live_count - 1; i++) slots[i] = slots[i + 1];
                    live_count--;
                    r = granted(STAT_OK, best, e);
                end
            end
            CMD_RESCHED: begin
                if (int'(it.position) >= live_count) begin
                    r = refused(STAT_BAD_POS);
                end else begin
                    e  = slots[it.position];
                    st = settle_date(dt, int'(it.position));
                    if (st == STAT_NO_DATE) begin
                        r = refused(st);
                    end else begin
                        e.date             = dt;
                        slots[it.position] = e;
                        r                  = granted(st, int'(it.position), e);
                    end
                end
            end
            default: begin
                has = 1'b0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic      has;
        t_out_item fresh;
        t_out_item want;
        if (!i_rst_n) begin
            live_count   = 0;
            bump_limit   = BUMP_RESET;
            o_fail_count = 0;
            awaited.delete();
        end else begin
            if (i_cfg_we) bump_limit = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                apply_command(i_in_data, has, fresh);
                if (has) awaited.push_back(fresh);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_count++;
                end else begin
                    want = awaited.pop_front();
                    check_field("status", 16'(want.status), 16'(i_out_data.status));
                    check_field("out_position", 16'(want.out_position),
                                16'(i_out_data.out_position));
                    check_field("out_worker", 16'(want.out_worker), 16'(i_out_data.out_worker));
                    check_field("out_urgency", 16'(want.out_urgency),
                                16'(i_out_data.out_urgency));
                    check_field("out_day", 16'(want.out_day), 16'(i_out_data.out_day));
                    check_field("out_month", 16'(want.out_month), 16'(i_out_data.out_month));
                    check_field("out_year", 16'(want.out_year), 16'(i_out_data.out_year));
                end
            end
        end
        o_pending = awaited.size();
    end

endmodule

@@ test/testbench.sv @@
// Testbench top for the booking priority queue: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
    import bpq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 50;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 300;
    localparam int PHASES        = 6;
    localparam int CALM_FROM     = 1550;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic calm        = 1'b0;
    logic hold_go     = 1'b0;
    logic hold_done   = 1'b0;

    always #5 clk = ~clk;

    booking_priority_queue_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    booking_checker check_u (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        int len;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                len       = $urandom_range(1, 12);
                out_ready = 1'b0;
                repeat (len - 1) @(negedge clk);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    function automatic t_in_item booking(input logic [1:0] cmd, input int worker, urgency,
                                         day, month, year, position);
        t_in_item it;
        it.cmd      = cmd;
        it.worker   = 3'(worker);
        it.urgency  = 3'(urgency);
        it.day      = 5'(day);
        it.month    = 4'(month);
        it.year     = 14'(year);
        it.position = 4'(position);
        return it;
    endfunction

    // dates cluster around a year end so that clashes and rollovers are common
    function automatic t_in_item roll_item(input int insert_pct);
        t_in_item it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) it.cmd = CMD_INSERT;
        else if (pick < 88)    it.cmd = CMD_TAKE;
        else if (pick < 97)    it.cmd = CMD_RESCHED;
        else                   it.cmd = CMD_UNUSED;
        it.worker  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
        it.urgency = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
        case ($urandom_range(0, 19))
            0:       it.year = 14'($urandom_range(0, 16383));
            1:       it.year = 14'd16383;
            default: it.year = 14'(2024 + $urandom_range(0, 1));
        endcase
        case ($urandom_range(0, 15))
            0:          it.month = 4'($urandom_range(0, 15));
            1, 2:       it.month = 4'($urandom_range(1, 12));
            3, 4, 5, 6, 7, 8: it.month = 4'd12;
            default:    it.month = 4'($urandom_range(1, 2));
        endcase
        case ($urandom_range(0, 9))
            0:          it.day = 5'($urandom_range(0, 31));
            1, 2, 3, 4: it.day = 5'($urandom_range(27, 31));
            default:    it.day = 5'($urandom_range(1, 3));
        endcase
        it.position = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic offer(input t_in_item it);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        t_in_item   it;
        int         sent;
        int         n;
        logic [3:0] bump_plan [PHASES];
        sent      = 0;
        bump_plan = '{4'd0, 4'd15, 4'($urandom_range(0, 15)), 4'd1, 4'd15, 4'd5};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // empty queue
        offer(booking(CMD_TAKE, 0, 1, 1, 1, 2024, 0));
        offer(booking(CMD_RESCHED, 0, 1, 1, 1, 2024, 0));
        // same date over and over, until the bump budget of 5 runs out
        offer(booking(CMD_INSERT, 0, 4, 31, 12, 2024, 0));
        offer(booking(CMD_INSERT, 1, 1, 31, 12, 2024, 0));
        offer(booking(CMD_INSERT, 2, 2, 31, 12, 2024, 0));
        offer(booking(CMD_INSERT, 0, 3, 31, 12, 2024, 0));
        offer(booking(CMD_INSERT, 1, 4, 31, 12, 2024, 0));
        offer(booking(CMD_INSERT, 2, 1, 31, 12, 2024, 0));
        offer(booking(CMD_INSERT, 3, 2, 31, 12, 2024, 0));
        // year wrap, odd urgencies
        offer(booking(CMD_INSERT, 3, 7, 31, 12, 16383, 0));
        offer(booking(CMD_INSERT, 4, 0, 31, 12, 16383, 0));
        // month 0 and day 0
        offer(booking(CMD_INSERT, 5, 2, 0, 0, 100, 0));
        offer(booking(CMD_INSERT, 5, 2, 0, 0, 100, 0));
        offer(booking(CMD_INSERT, 7, 5, 31, 15, 200, 0));
        offer(booking(CMD_INSERT, 6, 6, 31, 15, 200, 0));
        offer(booking(CMD_INSERT, 4, 3, 28, 2, 7, 0));
        offer(booking(CMD_INSERT, 3, 1, 28, 2, 7, 0));
        offer(booking(CMD_INSERT, 1, 2, 0, 3, 300, 15));
        offer(booking(CMD_INSERT, 2, 3, 0, 3, 300, 15));
        offer(booking(CMD_INSERT, 0, 1, 31, 12, 2024, 0));
        offer(booking(CMD_TAKE, 0, 0, 0, 0, 0, 0));
        offer(booking(CMD_TAKE, 6, 0, 0, 0, 0, 0));
        offer(booking(CMD_TAKE, 5, 0, 0, 0, 0, 0));
        offer(booking(CMD_RESCHED, 0, 0, 1, 1, 2025, 0));
        offer(booking(CMD_RESCHED, 0, 0, 1, 1, 2025, 1));
        offer(booking(CMD_TAKE, 1, 0, 0, 0, 0, 0));
        offer(booking(CMD_RESCHED, 0, 0, 1, 1, 2025, 15));
        offer(booking(CMD_UNUSED, 7, 7, 31, 15, 16383, 15));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            cfg_we    = 1'b1;
            cfg_wdata = bump_plan[ph];
            @(negedge clk);
            cfg_we = 1'b0;
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (ph == 1 && n == 50) hold_go = 1'b1;
                calm = (sent >= CALM_FROM);
                it   = roll_item((ph % 2 == 0) ? 30 : 60);
                offer(it);
                if (it.cmd != CMD_UNUSED) begin
                    n++;
                    sent++;
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
